@@ rtl/core/rgb_conv3x3_abs_clamp_assert.svh @@
// assertion macros used by the rtl queue
`ifndef RGB_CONV3X3_ABS_CLAMP_ASSERT_SVH
`define RGB_CONV3X3_ABS_CLAMP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RGBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RGBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rgbc_pkg.sv @@
`default_nettype none
package rgbc_pkg;
  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic [8:0][23:0] win;
    logic             pass;
    logic             last;
  } job_t;

  localparam int ACC_W     = 28;
  localparam int MAG_W     = 27;
  localparam int TAP_CNT   = 9;
  localparam int DIV_STEPS = MAG_W;
  localparam int CLAMP_MAX = 255;
  localparam int MIN_DIM   = 3;

  localparam logic [2:0] REG_WTOP   = 3'd0;
  localparam logic [2:0] REG_WMID   = 3'd1;
  localparam logic [2:0] REG_WBOT   = 3'd2;
  localparam logic [2:0] REG_DIV    = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
endpackage
`default_nettype wire

@@ rtl/core/rgbc_front.sv @@
`default_nettype none
module rgbc_front import rgbc_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = $clog2(MAX_WIDTH),
  parameter int WID_W     = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             opcode,
  input  wire pix_t             pix,
  input  wire logic [WID_W-1:0] w_eff,
  input  wire logic [15:0]      h_eff,
  input  wire logic             q_full,
  output logic                  q_push,
  output job_t                  q_job
);
  localparam logic F_IDLE = 1'b0;
  localparam logic F_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [15:0]      row_r, row_nxt;
  logic [WID_W-1:0] pend_r, pend_nxt;
  logic [COL_W-1:0] addr_r, addr_nxt;
  pix_t             pix_r, pix_nxt;
  logic             emit_r, emit_nxt;
  logic             pass_r, pass_nxt;
  logic             last_r, last_nxt;
  logic [8:0][23:0] win_r, win_nxt;

  pix_t mid_mem [MAX_WIDTH];
  pix_t top_mem [MAX_WIDTH];
  pix_t mid_rd_r, top_rd_r;

  logic [WID_W-1:0] w_m1, k;
  logic [COL_W-1:0] c_sel, ocol;
  logic [15:0]      orow;
  logic             accept, act;

  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign w_m1     = w_eff - WID_W'(1);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    addr_nxt  = addr_r;
    pix_nxt   = pix_r;
    emit_nxt  = 1'b0;
    pass_nxt  = pass_r;
    last_nxt  = 1'b0;
    act       = 1'b0;
    c_sel     = (WID_W'(col_r) >= w_eff) ? w_m1[COL_W-1:0] : col_r;
    k         = (pend_r > w_eff) ? w_eff : pend_r;
    orow      = row_r - 16'd1;
    ocol      = c_sel - COL_W'(1);
    if (state_r == F_RUN) begin
      state_nxt = F_IDLE;
    end else if (accept) begin
      if (!opcode) begin
        if (row_r < h_eff) begin
          act      = 1'b1;
          addr_nxt = c_sel;
          pix_nxt  = pix;
          emit_nxt = !((row_r == 16'd0) || ((row_r == 16'd1) && (c_sel == '0)));
          pass_nxt = (c_sel == '0) || (orow == 16'd0) || (orow >= h_eff - 16'd1) ||
                     (ocol == '0) || (WID_W'(ocol) >= w_m1);
          if (WID_W'(c_sel) + WID_W'(1) >= w_eff) begin
            col_nxt = '0;
            row_nxt = row_r + 16'd1;
          end else begin
            col_nxt = c_sel + COL_W'(1);
          end
        end
      end else if (row_r >= h_eff) begin
        act      = 1'b1;
        addr_nxt = (k < w_eff) ? k[COL_W-1:0] : '0;
        pix_nxt  = '0;
        emit_nxt = 1'b1;
        pass_nxt = 1'b1;
        last_nxt = (k == w_eff);
        if (k == w_eff) begin
          col_nxt  = '0;
          row_nxt  = '0;
          pend_nxt = '0;
        end else begin
          pend_nxt = k + WID_W'(1);
        end
      end
      if (act) begin
        state_nxt = F_RUN;
      end
    end
  end

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_rd_r;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_rd_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = pix_r;
  end

  assign q_push     = (state_r == F_RUN) && emit_r;
  assign q_job.win  = win_nxt;
  assign q_job.pass = pass_r;
  assign q_job.last = last_r;

  always_ff @(posedge clk) begin
    mid_rd_r <= mid_mem[addr_nxt];
    top_rd_r <= top_mem[addr_nxt];
    if (state_r == F_RUN) begin
      top_mem[addr_r] <= mid_rd_r;
      mid_mem[addr_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
      emit_r  <= 1'b0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      if (state_r == F_RUN) begin
        win_r  <= win_nxt;
        emit_r <= 1'b0;
      end else if (act) begin
        emit_r <= emit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      addr_r <= addr_nxt;
      pix_r  <= pix_nxt;
      pass_r <= pass_nxt;
      last_r <= last_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/rgbc_fifo.sv @@
`default_nettype none
module rgbc_fifo import rgbc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      full,
  output logic      empty
);
`include "rgb_conv3x3_abs_clamp_assert.svh"

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  `RGBC_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
  `RGBC_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
  `RGBC_ASSERT_NXT(a_push_only, clk, rst_n, push && !pop, count_r == $past(count_r) + 2'd1,
    "queue count did not follow a push")
endmodule
`default_nettype wire

@@ rtl/core/rgbc_back.sv @@
`default_nettype none
module rgbc_back import rgbc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire job_t         q_job,
  output logic              q_pop,
  input  wire logic [143:0] weights,
  input  wire logic [15:0]  divisor,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out,
  output logic              frame_last
);
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MAC  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_HOLD = 2'd3;

  logic [1:0]                  state_r;
  job_t                        job_r;
  logic [3:0]                  tap_r;
  logic [4:0]                  step_r;
  logic signed [2:0][ACC_W-1:0] acc_r;
  logic [2:0][MAG_W-1:0]       num_r;
  logic [2:0][15:0]            rem_r;
  pix_t                        res_r;
  logic                        out_valid_r;
  pix_t                        out_pix_r;
  logic                        out_last_r;

  logic signed [15:0]          wt;
  logic signed [2:0][24:0]     prod;
  logic [2:0][ACC_W-1:0]       acc_sum;
  logic [2:0][16:0]            rem_sh;
  logic [2:0]                  ge;
  pix_t                        clamped;
  logic                        out_free;

  assign wt       = weights[16*tap_r +: 16];
  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]    = $signed({1'b0, job_r.win[tap_r][8*ch +: 8]}) * wt;
      acc_sum[ch] = acc_r[ch] + ACC_W'($signed(prod[ch]));
      rem_sh[ch]  = {rem_r[ch], num_r[ch][MAG_W-1]};
      ge[ch]      = rem_sh[ch] >= {1'b0, divisor};
      clamped[8*ch +: 8] = (num_r[ch] > MAG_W'(CLAMP_MAX)) ? 8'(CLAMP_MAX)
                                                             : num_r[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            state_r <= q_job.pass ? B_HOLD : B_MAC;
          end
        end
        B_MAC: begin
          if (tap_r == 4'(TAP_CNT - 1)) begin
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          if (step_r == 5'(DIV_STEPS - 1)) begin
            state_r <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (out_free) begin
            state_r     <= B_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        job_r <= q_job;
        tap_r <= '0;
        acc_r <= '0;
        res_r <= q_job.win[4];
      end
      B_MAC: begin
        tap_r <= tap_r + 4'd1;
        for (int ch = 0; ch < 3; ch++) begin
          acc_r[ch] <= acc_sum[ch];
        end
        step_r <= '0;
        if (tap_r == 4'(TAP_CNT - 1)) begin
          for (int ch = 0; ch < 3; ch++) begin
            num_r[ch] <= acc_sum[ch][ACC_W-1] ? MAG_W'(-acc_sum[ch])
                                              : MAG_W'(acc_sum[ch]);
            rem_r[ch] <= '0;
          end
        end
      end
      B_DIV: begin
        step_r <= step_r + 5'd1;
        for (int ch = 0; ch < 3; ch++) begin
          rem_r[ch] <= ge[ch] ? 16'(rem_sh[ch] - {1'b0, divisor}) : rem_sh[ch][15:0];
          num_r[ch] <= {num_r[ch][MAG_W-2:0], ge[ch]};
        end
        if (step_r == 5'(DIV_STEPS - 1)) begin
          res_r <= '0;
        end
      end
      B_HOLD: begin
        if (out_free) begin
          out_pix_r  <= job_r.pass ? res_r : clamped;
          out_last_r <= job_r.last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign red_out    = out_pix_r[7:0];
  assign green_out  = out_pix_r[15:8];
  assign blue_out   = out_pix_r[23:16];
  assign frame_last = out_last_r;
endmodule
`default_nettype wire

@@ rtl/core/rgb_conv3x3_abs_clamp.sv @@
// rgb_conv3x3_abs_clamp: 3x3 convolution over an rgb raster stream
// input word: in_opcode 0 carries a pixel, 1 is a drain tick after frame end.
// output word: filtered or passed-through pixel, out_frame_last on the last
// pixel of a frame. both channels use valid/ready.
// cfg_we/cfg_index/cfg_data write kernel rows, divisor, width and height.
// the front takes a word only while idle and the queue is not full: a line memory
// read, then window shift and line memory write; the first line_width+1 pixels
// of a frame give no output, drain ticks push out the last line_width+1 pixels.
// an edge pixel is passed through; a filtered pixel goes through 9
// multiply-accumulate steps plus a 27-step restoring divide, in a shared
// multiply-accumulate and divide unit that takes no new pixel before it
// is through with the last one.
// a 2-entry queue sits between front and back; a stalled receiver holds the
// output register, then the queue fills, then in_ready drops.
// reset (rst_n low, synchronous) restores the registers to an identity kernel
// and clears counters and window; line memory is not cleared.
`default_nettype none
module rgb_conv3x3_abs_clamp import rgbc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_frame_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  logic [47:0] wtop_r, wmid_r, wbot_r;
  logic [15:0] div_r, height_r;
  logic [10:0] width_r;

  logic [WID_W-1:0] w_eff;
  logic [15:0]      h_eff, d_eff;
  logic             q_full, q_empty, q_push, q_pop;
  job_t             push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wtop_r   <= '0;
      wmid_r   <= 48'd65536;
      wbot_r   <= '0;
      div_r    <= 16'd1;
      width_r  <= 11'd1024;
      height_r <= 16'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WTOP:   wtop_r   <= cfg_data;
        REG_WMID:   wmid_r   <= cfg_data;
        REG_WBOT:   wbot_r   <= cfg_data;
        REG_DIV:    div_r    <= cfg_data[15:0];
        REG_WIDTH:  width_r  <= cfg_data[10:0];
        REG_HEIGHT: height_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(width_r) < 32'(MIN_DIM)) begin
      w_eff = WID_W'(MIN_DIM);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_r);
    end
    h_eff = (height_r < 16'(MIN_DIM)) ? 16'(MIN_DIM) : height_r;
    d_eff = (div_r == '0) ? 16'd1 : div_r;
  end

  rgbc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .WID_W     (WID_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (in_opcode),
    .pix      ({in_blue_in, in_green_in, in_red_in}),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  rgbc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  rgbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .weights    ({wbot_r, wmid_r, wtop_r}),
    .divisor    (d_eff),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (out_red_out),
    .green_out  (out_green_out),
    .blue_out   (out_blue_out),
    .frame_last (out_frame_last)
  );
endmodule
`default_nettype wire

@@ tb/tb_rgb_conv3x3_abs_clamp.sv @@
`timescale 1ns / 1ps
module tb_rgb_conv3x3_abs_clamp;
  import rgbc_pkg::*;

  localparam int MAX_W = 1024;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    pix_t pix;
    bit   last;
  } pixel_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = 1'b0;
  logic [7:0]  in_red_in = 8'd0;
  logic [7:0]  in_green_in = 8'd0;
  logic [7:0]  in_blue_in = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_frame_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [47:0] cfg_data = 48'd0;

  rgb_conv3x3_abs_clamp dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow registers
  logic [47:0] kern_top = 48'd0;
  logic [47:0] kern_mid = 48'd65536;
  logic [47:0] kern_bot = 48'd0;
  logic [15:0] div_reg = 16'd1;
  logic [10:0] width_reg = 11'd1024;
  logic [15:0] height_reg = 16'd3;

  // filter state
  pix_t prev_lines [0:2*MAX_W-1];
  pix_t win [0:8];
  int   col_pos = 0;
  int   row_pos = 0;
  int   drain_pos = 0;

  pixel_word_t expected_pixels[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    for (int i = 0; i < 2*MAX_W; i++) prev_lines[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
  end

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic int eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int eff_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic void shift_pixel(int c, pix_t p);
    pix_t top;
    pix_t mid;
    top = prev_lines[MAX_W + c];
    mid = prev_lines[c];
    prev_lines[MAX_W + c] = mid;
    prev_lines[c] = p;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = p;
  endfunction

  function automatic pix_t filter_pixel();
    logic [47:0] rows [0:2];
    longint sum;
    longint dv;
    pix_t res;
    rows[0] = kern_top;
    rows[1] = kern_mid;
    rows[2] = kern_bot;
    dv = (div_reg == 0) ? 1 : longint'(div_reg);
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          sum += longint'(win[r*3+c][8*ch +: 8]) * longint'($signed(rows[r][16*c +: 16]));
      sum = sum / dv;
      if (sum < 0) sum = -sum;
      if (sum > CLAMP_MAX) sum = CLAMP_MAX;
      res[8*ch +: 8] = sum[7:0];
    end
    return res;
  endfunction

  function automatic bit predict_word(bit op, pix_t p, output pixel_word_t o);
    int w;
    int h;
    int c;
    int r;
    int k;
    int orow;
    int ocol;
    bit ok;
    w = eff_width();
    h = eff_height();
    o.pix = '0;
    o.last = 1'b0;
    if (!op) begin
      c = col_pos;
      r = row_pos;
      if (r >= h) return 0;
      if (c >= w) c = w - 1;
      shift_pixel(c, p);
      ok = !(r == 0 || (r == 1 && c == 0));
      if (c == 0) begin
        orow = r - 2;
        ocol = w - 1;
      end else begin
        orow = r - 1;
        ocol = c - 1;
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
      if (!ok) return 0;
      if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) o.pix = win[4];
      else o.pix = filter_pixel();
      return 1;
    end
    if (row_pos < h) return 0;
    k = drain_pos;
    if (k > w) k = w;
    shift_pixel((k < w) ? k : 0, '0);
    o.pix = win[4];
    o.last = (k == w);
    if (k == w) begin
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
    end else begin
      drain_pos = k + 1;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    pixel_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected word r=%0d g=%0d b=%0d last=%0d", $time,
                 out_red_out, out_green_out, out_blue_out, out_frame_last);
      end else begin
        e = expected_pixels.pop_front();
        if (out_red_out !== e.pix[7:0] || out_green_out !== e.pix[15:8] ||
            out_blue_out !== e.pix[23:16] || out_frame_last !== e.last) begin
          errors++;
          $display("%0t: mismatch exp r=%0d g=%0d b=%0d l=%0d got r=%0d g=%0d b=%0d l=%0d",
                   $time, e.pix[7:0], e.pix[15:8], e.pix[23:16], e.last,
                   out_red_out, out_green_out, out_blue_out, out_frame_last);
        end
      end
    end
  end

  task automatic send_word(bit op, pix_t p);
    pixel_word_t o;
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_red_in <= p[7:0];
    in_green_in <= p[15:8];
    in_blue_in <= p[23:16];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (predict_word(op, p, o)) expected_pixels.push_back(o);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WTOP:   kern_top = val;
      REG_WMID:   kern_mid = val;
      REG_WBOT:   kern_bot = val;
      REG_DIV:    div_reg = val[15:0];
      REG_WIDTH:  width_reg = val[10:0];
      REG_HEIGHT: height_reg = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_t rand_pix();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic logic [47:0] rand_kernel_row(bit wide);
    logic [47:0] v;
    for (int i = 0; i < 3; i++) begin
      if (wide) v[16*i +: 16] = 16'($urandom);
      else v[16*i +: 16] = 16'($urandom_range(16) - 8);
    end
    return v;
  endfunction

  // pixels until the frame is complete, then drain ticks; noise is ignored
  task automatic finish_frame(int noise_pct);
    while (row_pos < eff_height()) begin
      if ($urandom_range(99) < noise_pct) send_word(1'b1, rand_pix());
      else send_word(1'b0, rand_pix());
    end
    while (row_pos >= eff_height()) begin
      if ($urandom_range(99) < noise_pct) send_word(1'b0, rand_pix());
      else send_word(1'b1, rand_pix());
    end
  endtask

  // one line and two pixels at the clamped width, then the frame ends narrow
  task automatic test_full_width();
    write_reg(REG_WTOP, rand_kernel_row(0));
    write_reg(REG_WMID, rand_kernel_row(0));
    write_reg(REG_WBOT, rand_kernel_row(0));
    write_reg(REG_DIV, 48'($urandom_range(1, 8)));
    write_reg(REG_WIDTH, 48'd2047);
    write_reg(REG_HEIGHT, 48'd3);
    for (int i = 0; i < MAX_W + 2; i++) send_word(1'b0, rand_pix());
    wait_idle();
    write_reg(REG_WIDTH, 48'd3);
    finish_frame(0);
    wait_idle();
  endtask

  task automatic test_edge_values();
    write_reg(REG_WTOP, {16'h8000, 16'h7fff, 16'h8000});
    write_reg(REG_WMID, {16'h7fff, 16'h8000, 16'h7fff});
    write_reg(REG_WBOT, {16'hffff, 16'h0001, 16'hffff});
    write_reg(REG_DIV, 48'd0);
    write_reg(REG_WIDTH, 48'd0);
    write_reg(REG_HEIGHT, 48'd0);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(1'b1, 24'hffffff);
      send_word(1'b0, (i % 2) ? 24'hffffff : 24'h000000);
    end
    send_word(1'b0, 24'h00ff00);
    finish_frame(0);
    wait_idle();
    write_reg(REG_DIV, 48'hffff);
    write_reg(REG_WMID, {16'h0000, 16'hffff, 16'h0000});
    for (int i = 0; i < 9; i++) send_word(1'b0, 24'hff00ff);
    finish_frame(0);
    wait_idle();
  endtask

  task automatic test_resize_mid_frame();
    write_reg(REG_DIV, 48'd1);
    write_reg(REG_WMID, {16'hffff, 16'h0004, 16'hffff});
    write_reg(REG_WIDTH, 48'd6);
    write_reg(REG_HEIGHT, 48'hffff);
    for (int i = 0; i < 11; i++) send_word(1'b0, rand_pix());
    wait_idle();
    write_reg(REG_WIDTH, 48'd4);
    for (int i = 0; i < 12; i++) send_word(1'b0, rand_pix());
    wait_idle();
    write_reg(REG_HEIGHT, 48'd3);
    finish_frame(0);
    wait_idle();
  endtask

  task automatic test_random(int gap, int stall, int n);
    int start;
    bit wide;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    start = items_sent;
    while (items_sent - start < n) begin
      wait_idle();
      wide = ($urandom_range(3) == 0);
      write_reg(REG_WTOP, rand_kernel_row(wide));
      write_reg(REG_WMID, rand_kernel_row(wide));
      write_reg(REG_WBOT, rand_kernel_row(wide));
      case ($urandom_range(9))
        0: write_reg(REG_DIV, 48'd0);
        1: write_reg(REG_DIV, 48'hffff);
        2: write_reg(REG_DIV, 48'($urandom_range(1, 65535)));
        default: write_reg(REG_DIV, 48'($urandom_range(1, 16)));
      endcase
      write_reg(REG_WIDTH, 48'($urandom_range(3, 12)));
      write_reg(REG_HEIGHT, 48'($urandom_range(3, 8)));
      finish_frame(4);
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_width();
    test_edge_values();
    test_resize_mid_frame();
    test_random(8, 84, 230);
    test_random(84, 8, 230);
    test_random(0, 0, 230);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_front.sv
rtl/core/rgbc_fifo.sv
rtl/core/rgbc_back.sv
rtl/core/rgb_conv3x3_abs_clamp.sv
tb/tb_rgb_conv3x3_abs_clamp.sv
